[rtl/ssu_pkg.sv]
// Shared types, constants and the rounding helper of the stiff string update core.
`default_nettype none
package ssu_pkg;

  localparam int WindowReach = 2;
  localparam int HistPoints  = 2 * WindowReach;
  localparam int CenterIdx   = WindowReach - 1;
  localparam int NumAxes     = 3;
  localparam int PosW        = 24;
  localparam int CoefW       = 18;
  localparam int NumCoef     = 7;
  localparam int QShift      = 14;
  localparam int SumW        = PosW + 1;
  localparam int ProdW       = CoefW + SumW;
  localparam int AccW        = ProdW + 3;
  localparam int CfgIdxW     = 3;
  localparam int PtsW        = 3;

  localparam logic [CfgIdxW-1:0] RegCenterNow = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNearNow   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegFarNow    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegCenterOld = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegNearOld   = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegFarOld    = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegForce     = CfgIdxW'(6);

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef pos_t  [NumAxes-1:0] vec_t;
  typedef coef_t [NumCoef-1:0] coefs_t;
  typedef prod_t [NumCoef-1:0] prods_t;
  typedef prods_t [NumAxes-1:0] ax_prods_t;

  typedef struct packed {
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
    pos_t old_x;
    pos_t old_y;
    pos_t old_z;
    pos_t force_x;
    pos_t force_y;
    pos_t force_z;
    logic last_point;
  } in_req_t;

  typedef struct packed {
    pos_t new_x;
    pos_t new_y;
    pos_t new_z;
    logic string_done;
  } out_req_t;

  typedef struct packed {
    pos_t c_pos;
    sum_t near_pos;
    sum_t far_pos;
    pos_t c_old;
    sum_t near_old;
    sum_t far_old;
    pos_t frc;
  } op_t;

  typedef op_t [NumAxes-1:0] ops_t;

  typedef struct packed {
    logic has_main;
    logic calc;
    logic has_mid;
    logic has_tail;
    vec_t center;
    vec_t mid;
    vec_t tail;
  } side_t;

  localparam acc_t RoundHalf = acc_t'(1 << (QShift - 1));
  localparam acc_t PosMax    = acc_t'((2 ** (PosW - 1)) - 1);
  localparam acc_t PosMin    = acc_t'(-(2 ** (PosW - 1)));

  function automatic pos_t round_sat(input acc_t acc);
    acc_t r;
    r = (acc + RoundHalf) >>> QShift;
    if (r > PosMax) begin
      return pos_t'(PosMax);
    end else if (r < PosMin) begin
      return pos_t'(PosMin);
    end
    return pos_t'(r);
  endfunction

endpackage
`default_nettype wire

[rtl/ssu_window.sv]
// Point window, string position counter and operand register of the update core.
`default_nettype none
module ssu_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssu_pkg::in_req_t in_data_i,
  input  logic             accept_i,
  input  logic             load_i,
  output logic             s1_valid_o,
  output ssu_pkg::ops_t    ops_o,
  output ssu_pkg::side_t   side_o
);
  import ssu_pkg::*;

  localparam logic [PtsW-1:0] PtsMax  = PtsW'(HistPoints);
  localparam logic [PtsW-1:0] PtsMain = PtsW'(WindowReach);

  vec_t pos_win_q [HistPoints];
  vec_t old_win_q [HistPoints];
  vec_t frc_win_q [WindowReach];
  logic [PtsW-1:0] pts_q, pts_d;
  logic  s1_valid_q;
  ops_t  ops_q, ops_d;
  side_t side_q, side_d;
  vec_t  cp, co, cf;

  always_comb begin
    cp[0] = in_data_i.pos_x;
    cp[1] = in_data_i.pos_y;
    cp[2] = in_data_i.pos_z;
    co[0] = in_data_i.old_x;
    co[1] = in_data_i.old_y;
    co[2] = in_data_i.old_z;
    cf[0] = in_data_i.force_x;
    cf[1] = in_data_i.force_y;
    cf[2] = in_data_i.force_z;
    for (int a = 0; a < NumAxes; a++) begin
      ops_d[a].c_pos    = pos_win_q[CenterIdx][a];
      ops_d[a].near_pos = sum_t'($signed(pos_win_q[CenterIdx-1][a]))
                        + sum_t'($signed(pos_win_q[CenterIdx+1][a]));
      ops_d[a].far_pos  = sum_t'($signed(cp[a]))
                        + sum_t'($signed(pos_win_q[HistPoints-1][a]));
      ops_d[a].c_old    = old_win_q[CenterIdx][a];
      ops_d[a].near_old = sum_t'($signed(old_win_q[CenterIdx-1][a]))
                        + sum_t'($signed(old_win_q[CenterIdx+1][a]));
      ops_d[a].far_old  = sum_t'($signed(co[a]))
                        + sum_t'($signed(old_win_q[HistPoints-1][a]));
      ops_d[a].frc      = frc_win_q[WindowReach-1][a];
    end
    side_d.has_main = (pts_q >= PtsMain);
    side_d.calc     = (pts_q >= PtsMax);
    side_d.has_mid  = in_data_i.last_point && (pts_q != '0);
    side_d.has_tail = in_data_i.last_point;
    side_d.center   = pos_win_q[CenterIdx];
    side_d.mid      = pos_win_q[0];
    side_d.tail     = cp;
  end

  always_comb begin
    pts_d = pts_q;
    if (in_data_i.last_point) begin
      pts_d = '0;
    end else if (pts_q < PtsMax) begin
      pts_d = pts_q + PtsW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < HistPoints; p++) begin
        pos_win_q[p] <= '0;
        old_win_q[p] <= '0;
      end
      for (int p = 0; p < WindowReach; p++) begin
        frc_win_q[p] <= '0;
      end
      pts_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        for (int p = HistPoints - 1; p >= 1; p--) begin
          pos_win_q[p] <= pos_win_q[p-1];
          old_win_q[p] <= old_win_q[p-1];
        end
        for (int p = WindowReach - 1; p >= 1; p--) begin
          frc_win_q[p] <= frc_win_q[p-1];
        end
        pos_win_q[0] <= cp;
        old_win_q[0] <= co;
        frc_win_q[0] <= cf;
        pts_q        <= pts_d;
      end
      if (load_i) begin
        s1_valid_q <= accept_i && (side_d.has_main || side_d.has_tail);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ops_q  <= ops_d;
      side_q <= side_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign ops_o      = ops_q;
  assign side_o     = side_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_data_i.last_point |=> pts_q == '0)
    else $error("point counter did not restart after the final point");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pts_q <= PtsMax)
    else $error("point counter beyond its limit");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !in_data_i.last_point && (pts_q < PtsMax)
    |=> pts_q == $past(pts_q) + PtsW'(1))
    else $error("point counter did not advance on an inner point");

endmodule
`default_nettype wire

[rtl/ssu_mult.sv]
// Coefficient multiplier stage: seven products per axis, registered.
`default_nettype none
module ssu_mult (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               s1_valid_i,
  input  ssu_pkg::ops_t      ops_i,
  input  ssu_pkg::side_t     side_i,
  input  ssu_pkg::coefs_t    coefs_i,
  output logic               s2_valid_o,
  output ssu_pkg::ax_prods_t prods_o,
  output ssu_pkg::side_t     side_o
);
  import ssu_pkg::*;

  ax_prods_t prods_d, prods_q;
  side_t     side_q;
  logic      s2_valid_q;

  function automatic prod_t mul(input coef_t c, input sum_t x);
    return prod_t'($signed(c)) * prod_t'($signed(x));
  endfunction

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      prods_d[a][RegCenterNow] = mul(coefs_i[RegCenterNow], sum_t'($signed(ops_i[a].c_pos)));
      prods_d[a][RegNearNow]   = mul(coefs_i[RegNearNow], ops_i[a].near_pos);
      prods_d[a][RegFarNow]    = mul(coefs_i[RegFarNow], ops_i[a].far_pos);
      prods_d[a][RegCenterOld] = mul(coefs_i[RegCenterOld], sum_t'($signed(ops_i[a].c_old)));
      prods_d[a][RegNearOld]   = mul(coefs_i[RegNearOld], ops_i[a].near_old);
      prods_d[a][RegFarOld]    = mul(coefs_i[RegFarOld], ops_i[a].far_old);
      prods_d[a][RegForce]     = mul(coefs_i[RegForce], sum_t'($signed(ops_i[a].frc)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (load_i) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prods_q <= prods_d;
      side_q  <= side_i;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign prods_o    = prods_q;
  assign side_o     = side_q;

endmodule
`default_nettype wire

[rtl/ssu_out.sv]
// Product summation, rounding and the result register that hands out up to three results.
`default_nettype none
module ssu_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s2_valid_i,
  input  ssu_pkg::ax_prods_t prods_i,
  input  ssu_pkg::side_t     side_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output ssu_pkg::out_req_t  out_data_o,
  output logic               ready_o
);
  import ssu_pkg::*;

  localparam int SlotMain = 0;
  localparam int SlotMid  = 1;
  localparam int SlotTail = 2;
  localparam int NumSlots = 3;

  logic [NumSlots-1:0] mask_q, mask_d, rest;
  vec_t main_d, main_q, mid_q, tail_q, sel;
  acc_t acc [NumAxes];
  logic fire, ready;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      acc[a] = '0;
      for (int c = 0; c < NumCoef; c++) begin
        acc[a] = acc[a] + acc_t'($signed(prods_i[a][c]));
      end
      main_d[a] = side_i.calc ? round_sat(acc[a]) : side_i.center[a];
    end
  end

  assign fire  = (mask_q != '0) && !out_stall_i;
  assign rest  = mask_q & (mask_q - NumSlots'(1));
  assign ready = (mask_q == '0) || (fire && (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (ready) begin
      mask_d = '0;
      if (s2_valid_i) begin
        mask_d[SlotMain] = side_i.has_main;
        mask_d[SlotMid]  = side_i.has_mid;
        mask_d[SlotTail] = side_i.has_tail;
      end
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      main_q <= main_d;
      mid_q  <= side_i.mid;
      tail_q <= side_i.tail;
    end
  end

  always_comb begin
    if (mask_q[SlotMain]) begin
      sel = main_q;
    end else if (mask_q[SlotMid]) begin
      sel = mid_q;
    end else begin
      sel = tail_q;
    end
  end

  assign out_valid_o            = (mask_q != '0);
  assign out_data_o.new_x       = sel[0];
  assign out_data_o.new_y       = sel[1];
  assign out_data_o.new_z       = sel[2];
  assign out_data_o.string_done = mask_q[SlotTail] && !mask_q[SlotMain] && !mask_q[SlotMid];
  assign ready_o                = ready;

  a_stall_holds_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0) && out_stall_i |=> $stable(mask_q))
    else $error("pending results changed while the receiver stalled");

endmodule
`default_nettype wire

[rtl/string_stencil_update_core.sv]
// Top level of the stiff string update core: coefficient registers and pipeline control.
//
// Mass points stream in on the input channel, one request per point, in string order;
// in_data_i.last_point marks the final point. Results leave on the output channel in
// point order. The input for point k releases the result for point k-2, and the final
// point also releases the results for the two points before it and itself, the last one
// with string_done set. The first two and last two points keep their position.
// Inner points go through at one request per cycle while the receiver does not stall;
// a final point holds the result register until all of its results have left, so the
// input can stall there until the result register frees up.
// The pipeline is a window register stage, a multiplier stage with 21 products and
// an adder, rounding and saturation stage feeding the result register.
// While the receiver stalls, the result register holds and the earlier stages keep
// taking requests until they are full, then in_stall_o rises.
// Coefficients are written through cfg_we_i, cfg_idx_i and cfg_wdata_i while the core
// is idle; an index beyond the seven coefficients is ignored.
// Reset clears the coefficients, the point window and the pipeline.
`default_nettype none
module string_stencil_update_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ssu_pkg::in_req_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ssu_pkg::out_req_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [ssu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ssu_pkg::CoefW-1:0]         cfg_wdata_i
);
  import ssu_pkg::*;

  coefs_t    coef_q;
  logic      s1_valid, s2_valid, s1_load, s2_load, out_ready, accept;
  ops_t      ops;
  side_t     side1, side2;
  ax_prods_t prods;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumCoef))) begin
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign s2_load    = !s2_valid || out_ready;
  assign s1_load    = !s1_valid || s2_load;
  assign accept     = in_valid_i && s1_load;
  assign in_stall_o = !s1_load;

  ssu_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .accept_i   (accept),
    .load_i     (s1_load),
    .s1_valid_o (s1_valid),
    .ops_o      (ops),
    .side_o     (side1)
  );

  ssu_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s2_load),
    .s1_valid_i (s1_valid),
    .ops_i      (ops),
    .side_i     (side1),
    .coefs_i    (coef_q),
    .s2_valid_o (s2_valid),
    .prods_o    (prods),
    .side_o     (side2)
  );

  ssu_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .prods_i     (prods),
    .side_i      (side2),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ready_o     (out_ready)
  );

endmodule
`default_nettype wire
